[design/frws_pkg.sv]
// shared constants and types for the frame rate window statistics block
package frws_pkg;
    localparam int          DEF_HISTORY_DEPTH = 64;
    localparam logic [31:0] RST_MIN_PERIOD    = 32'd1666666;
    localparam logic [31:0] RST_TICK_RATE     = 32'd100000000;
    localparam logic [31:0] RST_WINDOW        = 32'd25000000;
    localparam logic [1:0]  REG_MIN_PERIOD    = 2'd0;
    localparam logic [1:0]  REG_TICK_RATE     = 2'd1;
    localparam logic [1:0]  REG_WINDOW        = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch timestamp
        logic store;       // decide accept, latch timestamp difference
        logic div_start;
        logic walk_start;
        logic walk_step;
        logic avg_start;
        logic finish;      // commit statistics
    } frws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic div_done;
        logic walk_done;
        logic avg_done;
    } frws_sts_t;
endpackage

[design/frame_rate_window_stats_core.sv]
// top level of the frame rate window statistics block
// One request at a time: a rejected frame skips the divider and the walk; an accepted frame
// makes two passes through the shared 64-step divider (rate, then window mean) and
// one history read per walked entry.
// History memories are not cleared; a result is held until m_ready takes it.
module frame_rate_window_stats_core import frws_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_timestamp_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [31:0] m_period_ticks,
    output logic [31:0] m_current_rate,
    output logic [31:0] m_average_rate,
    output logic [31:0] m_lowest_rate,
    output logic [31:0] m_highest_rate,
    output logic [63:0] m_frame_total,
    output logic [63:0] m_elapsed_total_ticks,
    output logic [6:0]  m_window_entries
);
    frws_cmd_t cmd;
    frws_sts_t sts;

    frws_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    frws_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .timestamp(s_timestamp_ticks),
        .cmd(cmd), .sts(sts), .res_accepted(m_accepted), .res_period(m_period_ticks),
        .res_rate(m_current_rate), .res_avg(m_average_rate), .res_lo(m_lowest_rate),
        .res_hi(m_highest_rate), .res_frames(m_frame_total),
        .res_ticks(m_elapsed_total_ticks), .res_count(m_window_entries)
    );
endmodule

[design/frws_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle
module frws_divider import frws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) dvs_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

[design/frws_datapath.sv]
// history memories, totals, rate division and window accumulation
module frws_datapath import frws_pkg::*; #(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [63:0] timestamp,
    input  frws_cmd_t   cmd,
    output frws_sts_t   sts,
    output logic        res_accepted,
    output logic [31:0] res_period,
    output logic [31:0] res_rate,
    output logic [31:0] res_avg,
    output logic [31:0] res_lo,
    output logic [31:0] res_hi,
    output logic [63:0] res_frames,
    output logic [63:0] res_ticks,
    output logic [6:0]  res_count
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

    logic [31:0] min_period_reg, tick_rate_reg, window_reg;
    logic [31:0] period_mem [HISTORY_DEPTH];
    logic [31:0] rate_mem   [HISTORY_DEPTH];

    logic [63:0] ts_reg, last_reg, frames_reg, ticks_reg, diff_reg;
    logic [AW-1:0] wslot_reg, rd_slot_reg;
    logic        ok_reg;
    logic [31:0] newp_reg, newr_reg, avg_reg, lo_reg, hi_reg;
    logic [6:0]  count_out_reg;

    // walk state
    logic [CW-1:0] avail_reg, walked_reg;
    logic [31:0] rd_p_reg, rd_r_reg;
    logic        rd_vld_reg, stop_reg;
    logic [63:0] rsum_reg, tsum_reg;
    logic [31:0] wlo_reg, whi_reg;

    logic [63:0] div_q;
    logic        div_done;
    logic        div_start;
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic        rate_phase_reg;

    logic [63:0] diff;
    logic [31:0] psat;
    logic [31:0] rate_val;
    logic [63:0] tsum_new;

    assign diff = ts_reg - last_reg;
    assign psat = (diff_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg <= RST_MIN_PERIOD;
            tick_rate_reg  <= RST_TICK_RATE;
            window_reg     <= RST_WINDOW;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_PERIOD: min_period_reg <= cfg_data;
                REG_TICK_RATE:  tick_rate_reg  <= cfg_data;
                REG_WINDOW:     window_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // one divider for the rate and the mean
    assign div_start = cmd.div_start | cmd.avg_start;
    assign div_num   = cmd.avg_start ? rsum_reg : {16'd0, tick_rate_reg, 16'd0};
    assign div_den   = cmd.avg_start ? {{(32-CW){1'b0}}, walked_reg} : psat;

    frws_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_num), .divisor(div_den), .quotient(div_q), .done(div_done)
    );

    assign rate_val = (psat == 32'd0 || div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                               : div_q[31:0];
    assign tsum_new = tsum_reg + {32'd0, rd_p_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg       <= '0;
            frames_reg     <= '0;
            ticks_reg      <= '0;
            wslot_reg      <= '0;
            ok_reg         <= 1'b0;
            newp_reg       <= '0;
            newr_reg       <= '0;
            avg_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            count_out_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            stop_reg       <= 1'b0;
            rate_phase_reg <= 1'b0;
        end else begin
            rd_vld_reg <= 1'b0;
            if (cmd.capture) begin
                ts_reg <= timestamp;
            end
            if (cmd.store) begin
                // previous cycle settled ts_reg
                ok_reg   <= diff >= {32'd0, min_period_reg};
                diff_reg <= diff;
            end
            if (cmd.div_start) begin
                rate_phase_reg <= 1'b1;
                last_reg   <= ts_reg;
                frames_reg <= frames_reg + 64'd1;
                ticks_reg  <= ticks_reg + diff_reg;
            end
            if (div_done && rate_phase_reg) begin
                rate_phase_reg       <= 1'b0;
                period_mem[wslot_reg] <= psat;
                rate_mem[wslot_reg]   <= rate_val;
                newp_reg  <= psat;
                newr_reg  <= rate_val;
                wslot_reg <= (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + AW'(1);
            end
            if (cmd.walk_start) begin
                avail_reg  <= (frames_reg < 64'(HISTORY_DEPTH)) ? frames_reg[CW-1:0]
                                                               : CW'(HISTORY_DEPTH);
                walked_reg <= '0;
                rd_slot_reg <= (wslot_reg == '0) ? LAST_SLOT : wslot_reg - AW'(1);
                rsum_reg   <= '0;
                tsum_reg   <= '0;
                wlo_reg    <= 32'hFFFF_FFFF;
                whi_reg    <= '0;
                stop_reg   <= (frames_reg == 64'd0);
            end
            if (cmd.walk_step && !stop_reg) begin
                // issue read, fold previous read
                rd_vld_reg <= 1'b1;
                rd_p_reg   <= period_mem[rd_slot_reg];
                rd_r_reg   <= rate_mem[rd_slot_reg];
                rd_slot_reg <= (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - AW'(1);
            end
            if (rd_vld_reg && !stop_reg) begin
                rsum_reg   <= rsum_reg + {32'd0, rd_r_reg};
                tsum_reg   <= tsum_new;
                if (rd_r_reg < wlo_reg) wlo_reg <= rd_r_reg;
                if (rd_r_reg > whi_reg) whi_reg <= rd_r_reg;
                walked_reg <= walked_reg + CW'(1);
                if (tsum_new >= {32'd0, window_reg} || walked_reg + CW'(1) == avail_reg)
                    stop_reg <= 1'b1;
            end
            if (cmd.finish) begin
                if (walked_reg == '0) begin
                    avg_reg <= '0; lo_reg <= '0; hi_reg <= '0;
                end else begin
                    avg_reg <= div_q[31:0];
                    lo_reg  <= wlo_reg;
                    hi_reg  <= whi_reg;
                end
                count_out_reg <= 7'(walked_reg);
            end
        end
    end

    assign sts.ok        = ok_reg;
    assign sts.div_done  = div_done;
    assign sts.walk_done = stop_reg && !rd_vld_reg;
    assign sts.avg_done  = div_done;

    assign res_accepted = ok_reg;
    assign res_period   = frames_reg != 64'd0 ? newp_reg : 32'd0;
    assign res_rate     = frames_reg != 64'd0 ? newr_reg : 32'd0;
    assign res_avg      = avg_reg;
    assign res_lo       = lo_reg;
    assign res_hi       = hi_reg;
    assign res_frames   = frames_reg;
    assign res_ticks    = ticks_reg;
    assign res_count    = count_out_reg;
endmodule

[design/frws_ctrl.sv]
// sequencing state machine and output handshake
module frws_ctrl import frws_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  frws_sts_t sts,
    output frws_cmd_t cmd
);
    typedef enum logic [2:0] {
        IDLE, DECIDE, RATE, WALK_INIT, WALK, AVG, FIN, SEND
    } state_t;
    state_t state_reg;
    logic   m_valid_reg;
    logic   rate_kick_reg, avg_kick_reg;

    always_comb begin
        cmd = '0;
        cmd.capture    = (state_reg == IDLE) && s_valid;
        cmd.store      = (state_reg == DECIDE);
        cmd.walk_start = (state_reg == WALK_INIT);
        cmd.walk_step  = (state_reg == WALK) && !sts.walk_done;
        cmd.finish     = (state_reg == FIN);
        cmd.div_start  = rate_kick_reg && sts.ok;
        cmd.avg_start  = avg_kick_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE:      if (s_valid) state_reg <= DECIDE;
                DECIDE:    state_reg <= RATE;
                RATE: begin
                    // ok came from store; on reject go straight to send
                    if (!sts.ok) begin
                        state_reg   <= SEND;
                        m_valid_reg <= 1'b1;
                    end else if (sts.div_done) state_reg <= WALK_INIT;
                end
                WALK_INIT: state_reg <= WALK;
                WALK:      if (sts.walk_done) state_reg <= AVG;
                AVG:       if (sts.avg_done) state_reg <= FIN;
                FIN: begin
                    state_reg   <= SEND;
                    m_valid_reg <= 1'b1;
                end
                SEND: if (m_ready) begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // divider kicks are one-shot pulses on state entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_kick_reg <= 1'b0;
            avg_kick_reg  <= 1'b0;
        end else begin
            rate_kick_reg <= (state_reg == DECIDE);
            avg_kick_reg  <= (state_reg == WALK) && sts.walk_done;
        end
    end
    // walk_done is already set on entering WALK when walk_start sets stop; AVG waits on divider

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    a_vld_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == SEND) else $error("result valid outside send");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
endmodule
